// File: rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

   // Word width of the queue entries and of the push and pop data.
   localparam int DATA_BITS = 32;

   // Width of the capacity register and of the entry count.
   localparam int COUNT_BITS = 9;

   // Capacity after reset, before clamping to the ring depth.
   localparam int CAP_RESET = 256;

   // Smallest capacity the ring accepts.
   localparam int CAP_MIN = 2;

   // Operation codes carried on the request.
   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request into the datapath
      logic exec;   // carry out the captured operation
      logic fetch;  // take the popped word from the ring read port
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_go;  // the captured operation is a pop that will succeed
   } status_type;

endpackage

// File: rtl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Sequence: capture the request, execute it, and for a successful pop wait
   // in the read state for the ring read data.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.pop_go) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath follow directly from the state; load also needs start.
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.fetch = (state_ff == ST_READ);
   assign busy      = (state_ff != ST_IDLE);

   // A read wait only ever follows an execute step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(state_ff == ST_EXEC))
      else $error("read wait entered without an execute step");

   // A pop that succeeds always goes on to the read wait.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && status.pop_go |=> (state_ff == ST_READ))
      else $error("successful pop did not wait for read data");

endmodule

// File: rtl/cdq_dpath.sv
`timescale 1ns / 1ps

module cdq_dpath
   import cdq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic [1:0]                   req_opcode,
   input  logic signed [DATA_BITS-1:0]  req_push_value,
   input  logic                         csr_we,
   input  logic [COUNT_BITS-1:0]        csr_capacity,
   output logic                         rsp_strobe,
   output logic signed [DATA_BITS-1:0]  rsp_pop_value,
   output logic                         rsp_underflow,
   output logic                         rsp_overflow,
   output logic                         rsp_now_empty,
   output logic [COUNT_BITS-1:0]        rsp_entry_count
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Pointers stay below the capacity, which never exceeds the count range.
   localparam int PTR_BITS  = (ADDR_BITS < COUNT_BITS) ? ADDR_BITS : COUNT_BITS;
   localparam int EXT_BITS  = COUNT_BITS + 1;
   localparam int CAP_INIT  = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

   // Captured request.
   op_type                      op_ff;
   logic signed [DATA_BITS-1:0] value_ff;

   // Queue state.
   logic [COUNT_BITS-1:0] cap_ff,   cap_in;
   logic [PTR_BITS-1:0]   front_ff, front_in;
   logic [PTR_BITS-1:0]   back_ff,  back_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Result registers.
   logic                        strobe_ff,    strobe_in;
   logic signed [DATA_BITS-1:0] pop_value_ff;
   logic                        underflow_ff;
   logic                        overflow_ff;
   logic                        empty_ff;
   logic [COUNT_BITS-1:0]       count_out_ff;

   logic                  is_push;
   logic                  full;
   logic                  empty;
   logic [PTR_BITS-1:0]   front_next;
   logic [PTR_BITS-1:0]   back_prev;
   logic [PTR_BITS-1:0]   front_prev;
   logic [PTR_BITS-1:0]   back_next;
   logic [COUNT_BITS-1:0] cap_clamped;

   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic                  ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [DATA_BITS-1:0]  ram_rd_data;

   // Capture the request on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_opcode);
         value_ff <= req_push_value;
      end
   end

   // Queue occupancy tests.
   assign is_push = (op_ff == OP_PUSH_BACK) || (op_ff == OP_PUSH_FRONT);
   assign full    = (count_ff >= cap_ff);
   assign empty   = (count_ff == '0);
   assign status.pop_go = !is_push && !empty;

   // Pointer stepping with wrap at the capacity.
   assign front_next = (EXT_BITS'(front_ff) + EXT_BITS'(1) >= EXT_BITS'(cap_ff)) ?
                       '0 : PTR_BITS'(front_ff + 1'b1);
   assign back_next  = (EXT_BITS'(back_ff) + EXT_BITS'(1) >= EXT_BITS'(cap_ff)) ?
                       '0 : PTR_BITS'(back_ff + 1'b1);
   assign front_prev = (front_ff == '0) ? PTR_BITS'(cap_ff - 1'b1) :
                       PTR_BITS'(front_ff - 1'b1);
   assign back_prev  = (back_ff == '0) ? PTR_BITS'(cap_ff - 1'b1) :
                       PTR_BITS'(back_ff - 1'b1);

   // Out-of-range capacity writes are pulled to the nearest legal value.
   always_comb begin
      priority if (csr_capacity < COUNT_BITS'(CAP_MIN)) begin
         cap_clamped = COUNT_BITS'(CAP_MIN);
      end else if (32'(csr_capacity) > DEPTH) begin
         cap_clamped = COUNT_BITS'(DEPTH);
      end else begin
         cap_clamped = csr_capacity;
      end
   end

   // Next queue state and ring port controls.
   always_comb begin
      cap_in      = cap_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      count_in    = count_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_BITS'(back_ff);
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_BITS'(front_next);
      if (cmd.exec) begin
         unique case (op_ff)
            OP_PUSH_BACK: begin
               if (!full) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ADDR_BITS'(back_ff);
                  back_in     = back_next;
                  count_in    = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (!full) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ADDR_BITS'(front_ff);
                  front_in    = front_prev;
                  count_in    = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (!empty) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_BITS'(front_next);
                  front_in    = front_next;
                  count_in    = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (!empty) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_BITS'(back_prev);
                  back_in     = back_prev;
                  count_in    = count_ff - 1'b1;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      // A capacity write empties the queue.
      if (csr_we) begin
         cap_in   = cap_clamped;
         front_in = PTR_BITS'(cap_clamped - 1'b1);
         back_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= COUNT_BITS'(CAP_INIT);
         front_ff <= PTR_BITS'(CAP_INIT - 1);
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result strobe: in the cycle after execute, or after the read wait on a successful pop.
   assign strobe_in = (cmd.exec && !status.pop_go) || cmd.fetch;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   // Result fields are taken at execute; a successful pop fills in its word in the following cycle.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pop_value_ff <= '0;
         underflow_ff <= !is_push && empty;
         overflow_ff  <= is_push && full;
         count_out_ff <= count_in;
         empty_ff     <= (count_in == '0);
      end
      if (cmd.fetch) begin
         pop_value_ff <= $signed(ram_rd_data);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_pop_value   = pop_value_ff;
   assign rsp_underflow   = underflow_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_now_empty   = empty_ff;
   assign rsp_entry_count = count_out_ff;

   // The count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count exceeds capacity");

   // Both pointers stay inside the ring in use.
   assert property (@(posedge clock) disable iff (reset)
      (EXT_BITS'(front_ff) < EXT_BITS'(cap_ff)) && (EXT_BITS'(back_ff) < EXT_BITS'(cap_ff)))
      else $error("ring pointer beyond capacity");

   // A refused pop reports an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff && underflow_ff |-> empty_ff && (count_out_ff == '0) && !overflow_ff)
      else $error("underflow reported on a queue that is not empty");

   // Without a capacity write, the count moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) && !$past(reset) |->
         (count_ff == $past(count_ff)) ||
         (count_ff == $past(count_ff) + 1'b1) ||
         (count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");

endmodule

// File: rtl/circular_deque_top.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words held in a ring RAM.
// Requests: an operation is transferred at a rising edge where start is high
// and busy is low. req_opcode selects push back, push front, pop front or
// pop back; req_push_value is stored on a push and ignored on a pop.
// Results: one per request, shown on the rsp_ ports for exactly one cycle
// while rsp_strobe is high. There is no back-pressure; the receiver must take
// every result in the cycle it appears.
// Sequence: a push or a refused operation gives its result after the execute
// step, a successful pop only after the extra read wait for the registered
// RAM read. A new request may be transferred in the cycle the result is
// shown, but not before: each request passes through execute and, for a
// successful pop, the RAM read wait before the next one is taken.
// Configuration: csr_capacity sets the number of ring entries in use
// (clamped to 2 .. DEPTH) and empties the queue; csr_ready is high while
// the block is idle.
// Reset: the queue is empty and the capacity is 256 (or DEPTH if smaller).
// The RAM is not cleared; only written entries are ever read.
module circular_deque_top
   import cdq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic signed [DATA_BITS-1:0]  req_push_value,
   output logic                         rsp_strobe,
   output logic signed [DATA_BITS-1:0]  rsp_pop_value,
   output logic                         rsp_underflow,
   output logic                         rsp_overflow,
   output logic                         rsp_now_empty,
   output logic [COUNT_BITS-1:0]        rsp_entry_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [COUNT_BITS-1:0]        csr_capacity
);

   cmd_type    cmd;
   status_type status;
   logic       ctrl_busy;

   // Sequencer.
   cdq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (ctrl_busy)
   );

   // Queue state, ring RAM and result registers.
   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .csr_we          (csr_valid && csr_ready),
      .csr_capacity    (csr_capacity),
      .rsp_strobe      (rsp_strobe),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_underflow   (rsp_underflow),
      .rsp_overflow    (rsp_overflow),
      .rsp_now_empty   (rsp_now_empty),
      .rsp_entry_count (rsp_entry_count)
   );

   assign busy      = ctrl_busy;
   assign csr_ready = !ctrl_busy;

endmodule
